FILE: design/cst_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Shared codes, defaults, the queue entry type and the thread number reduction.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int unsigned DEF_NUM_SEMAPHORES = 64;
	localparam int unsigned DEF_NUM_THREADS    = 256;
	localparam int unsigned DEF_COUNT_BITS     = 16;

	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned SEARCH_GROUP = 32;

	localparam logic [1:0] ACT_CREATE  = 2'd0;
	localparam logic [1:0] ACT_DELETE  = 2'd1;
	localparam logic [1:0] ACT_WAIT    = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BLOCKED = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic        idx_ok;
		logic [5:0]  sem_index;
		logic [7:0]  tid;
		logic [7:0]  tid_red;
		logic [15:0] init;
	} entry_t;

	// Restoring reduction of an 8-bit thread number by the thread count.
	function automatic logic [7:0] thread_mod(input logic [7:0] v, input int unsigned m);
		logic [20:0] r;
		logic [20:0] d;
		r = {13'b0, v};
		for (int k = 7; k >= 0; k--) begin
			d = 21'(m) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[7:0];
	endfunction

endpackage

FILE: design/counting_semaphore_table.sv
// Delete, plain wait, plain release and bad handles finish in the execute state; create
// passes through the two find states, and a blocking wait on a busy queue or a release
// that wakes a thread goes on to a second state (ST_WAIT2, ST_REL2). The back end finishes
// one request before it takes the next from the queue, and it stalls while a response is held.
// Reset clears the slot bitmap, the request queue and the response valid flag at once.
// ----------------------------------------------------------------------------
// Counting semaphore table
// Table of counting semaphores with FIFO wait queues linked per thread.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
	parameter int unsigned NUM_SEMAPHORES = cst_pkg::DEF_NUM_SEMAPHORES,
	parameter int unsigned NUM_THREADS    = cst_pkg::DEF_NUM_THREADS,
	parameter int unsigned COUNT_BITS     = cst_pkg::DEF_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  action,
	input  logic [5:0]  sem_index,
	input  logic [7:0]  thread_id,
	input  logic [15:0] initial_count,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [5:0]  created_index,
	output logic        woken_valid,
	output logic [7:0]  woken_thread
);

	logic            q_valid;
	logic            q_pop;
	cst_pkg::entry_t q_entry;

	cst_front #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.NUM_THREADS(NUM_THREADS),
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.sem_index(sem_index),
		.thread_id(thread_id),
		.initial_count(initial_count),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_entry(q_entry)
	);

	cst_back #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.NUM_THREADS(NUM_THREADS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_entry(q_entry),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.created_index(created_index),
		.woken_valid(woken_valid),
		.woken_thread(woken_thread)
	);

	a_woken_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && woken_valid |-> status == cst_pkg::STAT_OK && created_index == 6'd0)
		else $error("woken thread reported with a non-ok status");

	a_full_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == cst_pkg::STAT_FULL |-> created_index == 6'd0 && !woken_valid)
		else $error("table full response carries a slot or a woken thread");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> q_valid)
		else $error("accepted request beat missing from the request queue");

endmodule

FILE: design/cst_front.sv
// ----------------------------------------------------------------------------
// Counting semaphore table front end
// Accepts request beats, checks the handle range, reduces the thread number,
// saturates the initial count and holds the results in a short queue.
// ----------------------------------------------------------------------------
module cst_front #(
	parameter int unsigned NUM_SEMAPHORES = cst_pkg::DEF_NUM_SEMAPHORES,
	parameter int unsigned NUM_THREADS    = cst_pkg::DEF_NUM_THREADS,
	parameter int unsigned COUNT_BITS     = cst_pkg::DEF_COUNT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        action,
	input  logic [5:0]        sem_index,
	input  logic [7:0]        thread_id,
	input  logic [15:0]       initial_count,
	output logic              q_valid,
	input  logic              q_pop,
	output cst_pkg::entry_t   q_entry
);

	localparam int unsigned DEPTH = cst_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW  = $clog2(DEPTH + 1);
	localparam int unsigned IDX_LIMIT = (NUM_SEMAPHORES >= 64) ? 64 : NUM_SEMAPHORES;
	localparam int unsigned INIT_MAX_I = (COUNT_BITS >= 16) ? 32'hFFFF
		: ((32'd1 << COUNT_BITS) - 32'd1);
	localparam logic [15:0] INIT_MAX = INIT_MAX_I[15:0];

	cst_pkg::entry_t fifo_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	cst_pkg::entry_t new_entry;
	logic            push;

	always_comb begin
		new_entry.action    = action;
		new_entry.idx_ok    = ({1'b0, sem_index} < 7'(IDX_LIMIT));
		new_entry.sem_index = sem_index;
		new_entry.tid       = thread_id;
		new_entry.tid_red   = cst_pkg::thread_mod(thread_id, NUM_THREADS);
		new_entry.init      = (initial_count > INIT_MAX) ? INIT_MAX : initial_count;
	end

	assign req_ready = (cnt_q != CNTW'(DEPTH));
	assign push      = req_valid && req_ready;
	assign q_valid   = (cnt_q != '0);
	assign q_entry   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !(q_pop && q_valid)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop && q_valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/cst_back.sv
// ----------------------------------------------------------------------------
// Counting semaphore table back end
// Sequencer that carries out queued operations against the slot bitmap, the
// semaphore memory and the thread link memory, and drives the response beat.
// ----------------------------------------------------------------------------
module cst_back #(
	parameter int unsigned NUM_SEMAPHORES = cst_pkg::DEF_NUM_SEMAPHORES,
	parameter int unsigned NUM_THREADS    = cst_pkg::DEF_NUM_THREADS,
	parameter int unsigned COUNT_BITS     = cst_pkg::DEF_COUNT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  cst_pkg::entry_t   q_entry,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        status,
	output logic [5:0]        created_index,
	output logic              woken_valid,
	output logic [7:0]        woken_thread
);

	localparam int unsigned SB   = $clog2(NUM_SEMAPHORES);
	localparam int unsigned TB   = $clog2(NUM_THREADS);
	localparam int unsigned CW   = COUNT_BITS;
	localparam int unsigned GS   = cst_pkg::SEARCH_GROUP;
	localparam int unsigned NG   = (NUM_SEMAPHORES + GS - 1) / GS;
	localparam int unsigned MAPW = (NG * GS > (1 << SB)) ? NG * GS : (1 << SB);
	localparam int unsigned SW   = CW + 25;
	localparam int unsigned TR_LSB  = 0;
	localparam int unsigned HD_LSB  = 8;
	localparam int unsigned HE_BIT  = 24;
	localparam int unsigned CNT_LSB = 25;
	localparam logic [16:0] LINK_END = 17'h10000;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_WAIT2  = 3'd2;
	localparam logic [2:0] ST_REL2   = 3'd3;
	localparam logic [2:0] ST_FIND_A = 3'd4;
	localparam logic [2:0] ST_FIND_B = 3'd5;

	logic [2:0]        state_q, state_d;
	cst_pkg::entry_t   cur_q;
	logic [MAPW-1:0]   valid_q;
	logic [SW-1:0]     sem_mem [NUM_SEMAPHORES];
	logic [16:0]       tn_mem [NUM_THREADS];
	logic [SW-1:0]     sem_rd_q;
	logic [16:0]       tn_rd_q;
	logic [NG-1:0]     grp_free_q;
	logic [4:0]        grp_pos_q [NG];
	logic [NG-1:0]     grp_free;
	logic [4:0]        grp_pos [NG];

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [5:0]        created_q;
	logic              woken_valid_q;
	logic [7:0]        woken_thread_q;

	logic [SB+5:0]     q_idx_ext, cur_idx_ext;
	logic [TB+7:0]     cur_tid_ext, tail_ext, head_ext;
	logic [SB-1:0]     q_slot, cur_slot, find_slot;
	logic [TB-1:0]     cur_tslot, tail_slot, head_slot;
	logic [CW+15:0]    init_ext;
	logic [CW-1:0]     cur_count;
	logic [SB+5:0]     find_ext;
	logic              find_ok;
	logic              cur_live, out_free, done, fire;

	logic              sem_we, sem_re, tn_we, tn_re, set_valid, clr_valid;
	logic [SB-1:0]     sem_wa;
	logic [SW-1:0]     sem_wd;
	logic [TB-1:0]     tn_wa;
	logic [16:0]       tn_wd;
	logic [1:0]        res_status;
	logic [5:0]        res_created;
	logic              res_wv;
	logic [7:0]        res_wt;

	assign q_idx_ext   = {SB'(0), q_entry.sem_index};
	assign cur_idx_ext = {SB'(0), cur_q.sem_index};
	assign q_slot      = q_idx_ext[SB-1:0];
	assign cur_slot    = cur_idx_ext[SB-1:0];
	assign cur_tid_ext = {TB'(0), cur_q.tid_red};
	assign tail_ext    = {TB'(0), sem_rd_q[TR_LSB +: 8]};
	assign head_ext    = {TB'(0), sem_rd_q[HD_LSB +: 8]};
	assign cur_tslot   = cur_tid_ext[TB-1:0];
	assign tail_slot   = tail_ext[TB-1:0];
	assign head_slot   = head_ext[TB-1:0];
	assign init_ext    = {CW'(0), cur_q.init};
	assign cur_count   = sem_rd_q[CNT_LSB +: CW];
	assign cur_live    = cur_q.idx_ok && valid_q[cur_slot];
	assign out_free    = !out_valid_q || rsp_ready;

	// First free slot inside each group of the bitmap.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_free[g] = 1'b0;
			grp_pos[g]  = '0;
			for (int b = GS - 1; b >= 0; b--) begin
				if (!valid_q[g * GS + b]) begin
					grp_free[g] = 1'b1;
					grp_pos[g]  = 5'(b);
				end
			end
		end
	end

	// Lowest group that has a free slot.
	always_comb begin
		int unsigned sel;
		sel     = 0;
		find_ok = 1'b0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_free_q[g]) begin
				find_ok = 1'b1;
				sel     = g * GS + grp_pos_q[g];
			end
		end
		find_ext  = (SB + 6)'(sel);
		find_slot = find_ext[SB-1:0];
	end

	always_comb begin
		logic [SB+5:0] created_ext;
		created_ext = {6'b0, find_slot};
		state_d     = state_q;
		q_pop       = 1'b0;
		done        = 1'b0;
		sem_we      = 1'b0;
		sem_re      = 1'b0;
		sem_wa      = cur_slot;
		sem_wd      = sem_rd_q;
		tn_we       = 1'b0;
		tn_re       = 1'b0;
		tn_wa       = cur_tslot;
		tn_wd       = LINK_END;
		set_valid   = 1'b0;
		clr_valid   = 1'b0;
		res_status  = cst_pkg::STAT_OK;
		res_created = '0;
		res_wv      = 1'b0;
		res_wt      = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					sem_re  = 1'b1;
					state_d = (q_entry.action == cst_pkg::ACT_CREATE) ? ST_FIND_A : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!cur_live) begin
					done       = 1'b1;
					res_status = cst_pkg::STAT_INVALID;
				end else begin
					case (cur_q.action)
						cst_pkg::ACT_DELETE: begin
							done      = 1'b1;
							clr_valid = 1'b1;
						end
						cst_pkg::ACT_WAIT: begin
							if (cur_count != '0) begin
								done   = 1'b1;
								sem_we = 1'b1;
								sem_wd[CNT_LSB +: CW] = cur_count - 1'b1;
							end else if (sem_rd_q[HE_BIT]) begin
								done       = 1'b1;
								res_status = cst_pkg::STAT_BLOCKED;
								sem_we     = 1'b1;
								sem_wd[HD_LSB +: 17] = {1'b0, cur_q.tid, cur_q.tid_red};
								sem_wd[TR_LSB +: 8]  = cur_q.tid_red;
								tn_we      = 1'b1;
							end else begin
								sem_we  = 1'b1;
								sem_wd[TR_LSB +: 8] = cur_q.tid_red;
								tn_we   = 1'b1;
								tn_wa   = tail_slot;
								tn_wd   = {1'b0, cur_q.tid, cur_q.tid_red};
								state_d = ST_WAIT2;
							end
						end
						cst_pkg::ACT_RELEASE: begin
							if (sem_rd_q[HE_BIT]) begin
								done   = 1'b1;
								sem_we = 1'b1;
								if (cur_count != '1) begin
									sem_wd[CNT_LSB +: CW] = cur_count + 1'b1;
								end
							end else begin
								tn_re   = 1'b1;
								state_d = ST_REL2;
							end
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			ST_WAIT2: begin
				done       = 1'b1;
				res_status = cst_pkg::STAT_BLOCKED;
				tn_we      = 1'b1;
			end
			ST_REL2: begin
				done   = 1'b1;
				res_wv = 1'b1;
				res_wt = sem_rd_q[HD_LSB + 8 +: 8];
				sem_we = 1'b1;
				sem_wd[HD_LSB +: 17] = tn_rd_q;
			end
			ST_FIND_A: begin
				state_d = ST_FIND_B;
			end
			ST_FIND_B: begin
				done = 1'b1;
				if (find_ok) begin
					set_valid   = 1'b1;
					sem_we      = 1'b1;
					sem_wa      = find_slot;
					sem_wd      = {init_ext[CW-1:0], LINK_END, 8'b0};
					res_created = created_ext[5:0];
				end else begin
					res_status  = cst_pkg::STAT_FULL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (done) begin
			if (out_free) begin
				state_d = ST_IDLE;
			end else begin
				sem_we    = 1'b0;
				tn_we     = 1'b0;
				set_valid = 1'b0;
				clr_valid = 1'b0;
				state_d   = state_q;
			end
		end
	end

	assign fire = done && out_free;

	always_ff @(posedge clk) begin
		if (sem_we) begin
			sem_mem[sem_wa] <= sem_wd;
		end
		if (sem_re) begin
			sem_rd_q <= sem_mem[q_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (tn_we) begin
			tn_mem[tn_wa] <= tn_wd;
		end
		if (tn_re) begin
			tn_rd_q <= tn_mem[head_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
		if (state_q == ST_FIND_A) begin
			grp_free_q <= grp_free;
			grp_pos_q  <= grp_pos;
		end
		if (fire) begin
			status_q       <= res_status;
			created_q      <= res_created;
			woken_valid_q  <= res_wv;
			woken_thread_q <= res_wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAPW; i++) begin
				valid_q[i] <= (i >= NUM_SEMAPHORES);
			end
		end else begin
			state_q <= state_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (set_valid) begin
				valid_q[find_slot] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[cur_slot] <= 1'b0;
			end
		end
	end

	assign rsp_valid     = out_valid_q;
	assign status        = status_q;
	assign created_index = created_q;
	assign woken_valid   = woken_valid_q;
	assign woken_thread  = woken_thread_q;

endmodule

FILE: dv/counting_semaphore_table_tb.sv
// ----------------------------------------------------------------------------
// Counting semaphore table testbench
// Drives create, delete, wait and release requests through the request channel
// and checks every response beat against a local model of the slot table, the
// counts and the linked wait queues. Both channels idle at random, and one
// phase holds the response channel off long enough to stall the request side.
// ----------------------------------------------------------------------------
module counting_semaphore_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSEM        = 64;
	localparam int unsigned NTHR        = 256;
	localparam logic [8:0]  LINK_END    = 9'h100;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_GAP     = 18;

	typedef struct {
		logic [1:0] status;
		logic [5:0] created;
		logic       woken;
		logic [7:0] woken_tid;
	} sem_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  action;
	logic [5:0]  sem_index;
	logic [7:0]  thread_id;
	logic [15:0] initial_count;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [1:0]  status;
	logic [5:0]  created_index;
	logic        woken_valid;
	logic [7:0]  woken_thread;

	bit          slot_used [NSEM];
	bit [15:0]   sem_count_m [NSEM];
	bit [8:0]    wait_head [NSEM];
	bit [7:0]    wait_tail [NSEM];
	bit [8:0]    thread_link [NTHR];

	sem_rsp_t    rsp_expect_q [$];
	int unsigned fail_cnt;
	int unsigned cycle_cnt;
	bit          req_idle;
	bit          rsp_idle;
	bit          rsp_hold;
	bit          hold_req;
	int unsigned hold_len;
	int unsigned rsp_gap;
	int unsigned rsp_gap_nxt;

	counting_semaphore_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.action        (action),
		.sem_index     (sem_index),
		.thread_id     (thread_id),
		.initial_count (initial_count),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.created_index (created_index),
		.woken_valid   (woken_valid),
		.woken_thread  (woken_thread)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("counting_semaphore_table: mismatch");
			$finish;
		end
	end

	function automatic sem_rsp_t sem_table_apply(input logic [1:0] act, input logic [5:0] idx,
		input logic [7:0] tid, input logic [15:0] cnt);
		sem_rsp_t r;
		int found;
		r = '{cst_pkg::STAT_OK, 6'd0, 1'b0, 8'd0};
		found = -1;
		if (act == cst_pkg::ACT_CREATE) begin
			for (int s = NSEM - 1; s >= 0; s--) begin
				if (!slot_used[s]) begin
					found = s;
				end
			end
			if (found < 0) begin
				r.status = cst_pkg::STAT_FULL;
			end else begin
				slot_used[found]   = 1'b1;
				sem_count_m[found] = cnt;
				wait_head[found]   = LINK_END;
				wait_tail[found]   = 8'd0;
				r.created          = found[5:0];
			end
		end else if (!slot_used[idx]) begin
			r.status = cst_pkg::STAT_INVALID;
		end else if (act == cst_pkg::ACT_DELETE) begin
			slot_used[idx] = 1'b0;
		end else if (act == cst_pkg::ACT_WAIT) begin
			if (sem_count_m[idx] != 16'd0) begin
				sem_count_m[idx] = sem_count_m[idx] - 16'd1;
			end else begin
				if (wait_head[idx][8]) begin
					wait_head[idx] = {1'b0, tid};
				end else begin
					thread_link[wait_tail[idx]] = {1'b0, tid};
				end
				wait_tail[idx]   = tid;
				thread_link[tid] = LINK_END;
				r.status         = cst_pkg::STAT_BLOCKED;
			end
		end else begin
			if (wait_head[idx][8]) begin
				if (sem_count_m[idx] != COUNT_MAX) begin
					sem_count_m[idx] = sem_count_m[idx] + 16'd1;
				end
			end else begin
				r.woken        = 1'b1;
				r.woken_tid    = wait_head[idx][7:0];
				wait_head[idx] = thread_link[wait_head[idx][7:0]];
			end
		end
		return r;
	endfunction

	function automatic void check_response();
		sem_rsp_t exp_r;
		if (rsp_expect_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= 10) begin
				$display("response beat with nothing outstanding: status %0d created %0d woken %0b/%0d",
					status, created_index, woken_valid, woken_thread);
			end
			return;
		end
		exp_r = rsp_expect_q.pop_front();
		if (status !== exp_r.status || created_index !== exp_r.created ||
			woken_valid !== exp_r.woken || woken_thread !== exp_r.woken_tid) begin
			fail_cnt++;
			if (fail_cnt <= 10) begin
				$display("wrong response at cycle %0d: expected %0d/%0d/%0b/%0d got %0d/%0d/%0b/%0d",
					cycle_cnt, exp_r.status, exp_r.created, exp_r.woken, exp_r.woken_tid,
					status, created_index, woken_valid, woken_thread);
			end
		end
	endfunction

	// Response side: with response idling on, a fresh stall length is drawn after every accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap   <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				check_response();
				rsp_gap_nxt = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
			end else if (rsp_gap != 0) begin
				rsp_gap_nxt = rsp_gap - 1;
			end else begin
				rsp_gap_nxt = 0;
			end
			rsp_gap   <= rsp_gap_nxt;
			rsp_ready <= (rsp_gap_nxt == 0) && !rsp_hold;
		end
	end

	initial begin
		rsp_hold = 1'b0;
		forever begin
			wait (hold_req);
			@(posedge clk);
			rsp_hold <= 1'b1;
			repeat (hold_len) @(posedge clk);
			rsp_hold <= 1'b0;
			hold_req = 1'b0;
		end
	end

	task automatic send_request(input logic [1:0] act, input logic [5:0] idx,
		input logic [7:0] tid, input logic [15:0] cnt);
		int unsigned gap;
		gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		action        <= act;
		sem_index     <= idx;
		thread_id     <= tid;
		initial_count <= cnt;
		do @(posedge clk); while (!req_ready);
		rsp_expect_q.push_back(sem_table_apply(act, idx, tid, cnt));
	endtask

	task automatic test_directed_cases();
		req_idle = 1'b1;
		rsp_idle <= 1'b1;
		send_request(cst_pkg::ACT_WAIT, 6'd0, 8'd3, 16'd0);
		send_request(cst_pkg::ACT_RELEASE, 6'd63, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_DELETE, 6'd5, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_CREATE, 6'd0, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_CREATE, 6'd63, 8'd255, COUNT_MAX);
		send_request(cst_pkg::ACT_CREATE, 6'd0, 8'd0, 16'd1);
		send_request(cst_pkg::ACT_RELEASE, 6'd1, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd1, 8'hAA, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd2, 8'h55, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd2, 8'hFF, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd2, 8'h00, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd2, 8'hFF, 16'd0);
		send_request(cst_pkg::ACT_RELEASE, 6'd2, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_RELEASE, 6'd2, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd0, 8'd7, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd0, 8'd9, 16'd0);
		send_request(cst_pkg::ACT_RELEASE, 6'd0, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_WAIT, 6'd0, 8'd11, 16'd0);
		send_request(cst_pkg::ACT_DELETE, 6'd0, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_RELEASE, 6'd0, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_CREATE, 6'd0, 8'd0, 16'd2);
		send_request(cst_pkg::ACT_RELEASE, 6'd0, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_DELETE, 6'd63, 8'd0, 16'd0);
	endtask

	task automatic test_table_full();
		req_idle = 1'b0;
		rsp_idle <= 1'b0;
		for (int s = 0; s < NSEM; s++) begin
			send_request(cst_pkg::ACT_CREATE, 6'($urandom_range(0, 63)),
				8'($urandom_range(0, 255)), 16'($urandom_range(0, 3)));
		end
		send_request(cst_pkg::ACT_DELETE, 6'd37, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_CREATE, 6'd0, 8'd0, 16'd0);
		send_request(cst_pkg::ACT_CREATE, 6'd0, 8'd0, 16'd5);
	endtask

	task automatic test_random_traffic(input int unsigned n_items, input bit idle);
		int unsigned roll;
		int unsigned p_create;
		int          live_q [$];
		logic [1:0]  act;
		logic [5:0]  idx;
		logic [7:0]  tid;
		logic [15:0] cnt;
		req_idle = idle;
		rsp_idle <= idle;
		for (int unsigned k = 0; k < n_items; k++) begin
			live_q.delete();
			for (int s = 0; s < NSEM; s++) begin
				if (slot_used[s]) begin
					live_q.push_back(s);
				end
			end
			p_create = (live_q.size() < 8) ? 35 : ((live_q.size() > 56) ? 4 : 12);
			roll = $urandom_range(0, 99);
			if (roll < p_create) begin
				act = cst_pkg::ACT_CREATE;
			end else if (roll < p_create + 8) begin
				act = cst_pkg::ACT_DELETE;
			end else if (roll < p_create + 8 + (92 - p_create) / 2) begin
				act = cst_pkg::ACT_WAIT;
			end else begin
				act = cst_pkg::ACT_RELEASE;
			end
			if (live_q.size() != 0 && $urandom_range(0, 99) < 88) begin
				idx = 6'(live_q[$urandom_range(0, live_q.size() - 1)]);
			end else begin
				idx = 6'($urandom_range(0, 63));
			end
			tid = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0: begin
					cnt = COUNT_MAX;
				end
				1: begin
					cnt = COUNT_MAX - 16'd1;
				end
				2, 3: begin
					cnt = 16'($urandom_range(0, 65535));
				end
				default: begin
					cnt = 16'($urandom_range(0, 3));
				end
			endcase
			send_request(act, idx, tid, cnt);
		end
	endtask

	task automatic test_backpressure();
		hold_len = 500;
		hold_req = 1'b1;
		test_random_traffic(40, 1'b0);
	endtask

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		action        = cst_pkg::ACT_CREATE;
		sem_index     = 6'd0;
		thread_id     = 8'd0;
		initial_count = 16'd0;
		fail_cnt      = 0;
		cycle_cnt     = 0;
		hold_req      = 1'b0;
		hold_len      = 0;
		req_idle      = 1'b0;
		rsp_idle      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_table_full();
		test_random_traffic(350, 1'b1);
		test_backpressure();
		test_random_traffic(300, 1'b0);
		test_random_traffic(400, 1'b1);

		req_valid <= 1'b0;
		while (rsp_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("counting_semaphore_table: match");
		end else begin
			$display("counting_semaphore_table: mismatch");
		end
		$finish;
	end

endmodule
